[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define RM2Q_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset too.
`define RM2Q_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/rm2q_pkg.sv]
// Shared types and constants of the matrix to quaternion converter.
`default_nettype none
package rm2q_pkg;
  localparam int DATA_W = 16;
  localparam int MAG_W  = 17;  // magnitude of an off-diagonal sum or difference
  localparam int Q_W    = 17;  // quotient bits produced by the divider
  localparam int LANES  = 4;

  // Component chosen as sqrt/2
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;
  localparam logic [1:0] SEL_W = 2'd3;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic             vld;
    logic             bad;
    logic [1:0]       sel;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] ovf;
  } ctrl_t;
endpackage
`default_nettype wire

[rtl/rm2q_front.sv]
// Branch choice, radicand and numerator magnitudes; first pipeline stage.
`default_nettype none
module rm2q_front #(
  parameter int FRAC_BITS = 14,
  parameter int RAD_W     = 20,
  parameter int VP_W      = 34
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     en,
  input  wire logic                                     in_vld,
  input  wire logic signed [rm2q_pkg::DATA_W-1:0]       r11, r12, r13,
  input  wire logic signed [rm2q_pkg::DATA_W-1:0]       r21, r22, r23,
  input  wire logic signed [rm2q_pkg::DATA_W-1:0]       r31, r32, r33,
  output rm2q_pkg::ctrl_t                               ctrl,
  output logic [VP_W-1:0]                               v,
  output logic [rm2q_pkg::LANES-1:0][rm2q_pkg::MAG_W-1:0] mag
);
  import rm2q_pkg::*;

  logic signed [RAD_W-1:0] e11, e22, e33, one, rad;
  logic                    tr_pos, row1, row2;
  logic [1:0]              sel;
  logic signed [MAG_W-1:0] n [LANES];
  logic signed [MAG_W-1:0] dx, sy, sz, dw, s12, s23, s13, d12;

  assign e11 = RAD_W'(r11);
  assign e22 = RAD_W'(r22);
  assign e33 = RAD_W'(r33);
  assign one = RAD_W'(1) << FRAC_BITS;
  assign tr_pos = (e11 + e22 + e33) > 0;
  assign row1 = (r11 > r22) && (r11 > r33);
  assign row2 = r22 > r33;

  // Off-diagonal sums and differences
  assign dx  = MAG_W'(r32) - MAG_W'(r23);
  assign sy  = MAG_W'(r13) - MAG_W'(r31);
  assign sz  = MAG_W'(r21) - MAG_W'(r12);
  assign s12 = MAG_W'(r12) + MAG_W'(r21);
  assign s13 = MAG_W'(r13) + MAG_W'(r31);
  assign s23 = MAG_W'(r23) + MAG_W'(r32);
  assign d12 = sz;
  assign dw  = dx;

  // Select branch, radicand and numerators
  always_comb begin
    n[0] = '0; n[1] = '0; n[2] = '0; n[3] = '0;
    if (tr_pos) begin
      sel = SEL_W;
      rad = one + e11 + e22 + e33;
      n[0] = dx; n[1] = sy; n[2] = sz;
    end else if (row1) begin
      sel = SEL_X;
      rad = one + e11 - e22 - e33;
      n[1] = s12; n[2] = s13; n[3] = dw;
    end else if (row2) begin
      sel = SEL_Y;
      rad = one + e22 - e11 - e33;
      n[0] = s12; n[2] = s23; n[3] = sy;
    end else begin
      sel = SEL_Z;
      rad = one + e33 - e11 - e22;
      n[0] = s13; n[1] = s23; n[3] = d12;
    end
  end

  // Register control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (en) begin
      ctrl.vld <= in_vld;
      ctrl.bad <= !(rad > 0);
      ctrl.sel <= sel;
      ctrl.ovf <= '0;
      for (int i = 0; i < LANES; i++) ctrl.neg[i] <= n[i][MAG_W-1];
    end
  end

  // Register payload
  always_ff @(posedge clk) begin
    if (en) begin
      v <= VP_W'(rad[RAD_W-2:0]) << FRAC_BITS;
      for (int i = 0; i < LANES; i++) begin
        mag[i] <= n[i][MAG_W-1] ? MAG_W'(-n[i]) : MAG_W'(n[i]);
      end
    end
  end
endmodule
`default_nettype wire

[rtl/rm2q_sqrt_step.sv]
// One digit of the pipelined integer square root.
`default_nettype none
module rm2q_sqrt_step #(
  parameter int VP_W = 34,
  parameter int SQ_W = 17
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        en,
  input  wire rm2q_pkg::ctrl_t                             ctrl_in,
  input  wire logic [VP_W-1:0]                             v_in,
  input  wire logic [SQ_W-1:0]                             root_in,
  input  wire logic [SQ_W+1:0]                             rem_in,
  input  wire logic [rm2q_pkg::LANES-1:0][rm2q_pkg::MAG_W-1:0] mag_in,
  output rm2q_pkg::ctrl_t                                  ctrl_out,
  output logic [VP_W-1:0]                                  v_out,
  output logic [SQ_W-1:0]                                  root_out,
  output logic [SQ_W+1:0]                                  rem_out,
  output logic [rm2q_pkg::LANES-1:0][rm2q_pkg::MAG_W-1:0]  mag_out
);
  import rm2q_pkg::*;

  logic [SQ_W+1:0] rs, trial;
  logic            ge;

  // Bring down two bits and try the next root bit
  assign rs    = {rem_in[SQ_W-1:0], v_in[VP_W-1 -: 2]};
  assign trial = {root_in, 2'b01};
  assign ge    = rs >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out    <= v_in << 2;
      root_out <= {root_in[SQ_W-2:0], ge};
      rem_out  <= ge ? rs - trial : rs;
      mag_out  <= mag_in;
    end
  end
endmodule
`default_nettype wire

[rtl/rm2q_div_step.sv]
// One quotient bit for all four lanes of the restoring divider.
`default_nettype none
module rm2q_div_step #(
  parameter int D_W  = 18,
  parameter int DR_W = 19
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         en,
  input  wire rm2q_pkg::ctrl_t                              ctrl_in,
  input  wire logic [D_W-1:0]                               d_in,
  input  wire logic [rm2q_pkg::LANES-1:0][DR_W-1:0]         rem_in,
  input  wire logic [rm2q_pkg::LANES-1:0][rm2q_pkg::Q_W-1:0] lo_in,
  input  wire logic [rm2q_pkg::LANES-1:0][rm2q_pkg::Q_W-1:0] q_in,
  output rm2q_pkg::ctrl_t                                   ctrl_out,
  output logic [D_W-1:0]                                    d_out,
  output logic [rm2q_pkg::LANES-1:0][DR_W-1:0]              rem_out,
  output logic [rm2q_pkg::LANES-1:0][rm2q_pkg::Q_W-1:0]     lo_out,
  output logic [rm2q_pkg::LANES-1:0][rm2q_pkg::Q_W-1:0]     q_out
);
  import rm2q_pkg::*;

  logic [LANES-1:0][DR_W-1:0] rs;
  logic [LANES-1:0]           ge;

  // Shift in the next numerator bit and subtract where it fits
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rs[i] = {rem_in[i][DR_W-2:0], lo_in[i][Q_W-1]};
      ge[i] = rs[i] >= DR_W'(d_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_in;
      for (int i = 0; i < LANES; i++) begin
        rem_out[i] <= ge[i] ? rs[i] - DR_W'(d_in) : rs[i];
        lo_out[i]  <= lo_in[i] << 1;
        q_out[i]   <= {q_in[i][Q_W-2:0], ge[i]};
      end
    end
  end
endmodule
`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix to quaternion converter, fully pipelined.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------------
//  s_*     | in  | tdata: r11 r12 r13 r21 r22 r23 r31 r32 r33, 16 bits each
//  m_*     | out | tdata: qx qy qz qw, 16 bits each; tuser: bad_input
//
// One matrix enters per cycle while the output is not stalled. The pipeline is
// one front stage, one stage per root bit, one stage per quotient bit and one
// output register. Reset clears only the control words and the output valid bit.
// A stalled output holds the whole pipeline; s_tready drops only while a
// beat waits at the output and m_tready is low.
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [143:0] s_tdata,   // r11 r12 r13 r21 r22 r23 r31 r32 r33
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [63:0]       m_tdata,   // qx qy qz qw
  output logic [0:0]        m_tuser    // bad_input
);
  import rm2q_pkg::*;

  localparam int RAD_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int V_W   = RAD_W - 1 + FRAC_BITS;
  localparam int VP_W  = V_W + (V_W % 2);
  localparam int SQ_W  = VP_W / 2;
  localparam int D_W   = SQ_W + 1;
  localparam int DR_W  = SQ_W + 2;
  localparam int N_W   = MAG_W + FRAC_BITS + 1;
  localparam int HI_W  = N_W - Q_W;

  logic en;

  ctrl_t                      sq_ctrl [0:SQ_W];
  logic [VP_W-1:0]            sq_v    [0:SQ_W];
  logic [SQ_W-1:0]            sq_root [0:SQ_W];
  logic [SQ_W+1:0]            sq_rem  [0:SQ_W];
  logic [LANES-1:0][MAG_W-1:0] sq_mag [0:SQ_W];

  ctrl_t                       dv_ctrl [0:Q_W];
  logic [D_W-1:0]              dv_d    [0:Q_W];
  logic [LANES-1:0][DR_W-1:0]  dv_rem  [0:Q_W];
  logic [LANES-1:0][Q_W-1:0]   dv_lo   [0:Q_W];
  logic [LANES-1:0][Q_W-1:0]   dv_q    [0:Q_W];

  // Advance everything together unless the output beat is stuck
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  rm2q_front #(.FRAC_BITS(FRAC_BITS), .RAD_W(RAD_W), .VP_W(VP_W)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_vld(s_tvalid),
    .r11(s_tdata[15:0]),    .r12(s_tdata[31:16]),   .r13(s_tdata[47:32]),
    .r21(s_tdata[63:48]),   .r22(s_tdata[79:64]),   .r23(s_tdata[95:80]),
    .r31(s_tdata[111:96]),  .r32(s_tdata[127:112]), .r33(s_tdata[143:128]),
    .ctrl(sq_ctrl[0]), .v(sq_v[0]), .mag(sq_mag[0])
  );
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  // Square root, one bit per stage
  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    rm2q_sqrt_step #(.VP_W(VP_W), .SQ_W(SQ_W)) u_step (
      .clk(clk), .rst(rst), .en(en),
      .ctrl_in(sq_ctrl[k]), .v_in(sq_v[k]), .root_in(sq_root[k]),
      .rem_in(sq_rem[k]), .mag_in(sq_mag[k]),
      .ctrl_out(sq_ctrl[k+1]), .v_out(sq_v[k+1]), .root_out(sq_root[k+1]),
      .rem_out(sq_rem[k+1]), .mag_out(sq_mag[k+1])
    );
  end

  // Form numerators and flag quotients that cannot fit
  always_comb begin
    logic [N_W-1:0]  num;
    logic [HI_W-1:0] hi;
    logic            ovf;
    dv_ctrl[0] = sq_ctrl[SQ_W];
    dv_d[0]    = {sq_root[SQ_W], 1'b0};
    for (int i = 0; i < LANES; i++) begin
      num = (N_W'(sq_mag[SQ_W][i]) << FRAC_BITS) + N_W'(sq_root[SQ_W]);
      hi  = num[N_W-1:Q_W];
      ovf = DR_W'(hi) >= DR_W'(dv_d[0]);
      dv_ctrl[0].ovf[i] = ovf;
      dv_rem[0][i] = ovf ? '0 : DR_W'(hi);
      dv_lo[0][i]  = num[Q_W-1:0];
      dv_q[0][i]   = '0;
    end
  end

  // Division, one quotient bit per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    rm2q_div_step #(.D_W(D_W), .DR_W(DR_W)) u_step (
      .clk(clk), .rst(rst), .en(en),
      .ctrl_in(dv_ctrl[k]), .d_in(dv_d[k]), .rem_in(dv_rem[k]),
      .lo_in(dv_lo[k]), .q_in(dv_q[k]),
      .ctrl_out(dv_ctrl[k+1]), .d_out(dv_d[k+1]), .rem_out(dv_rem[k+1]),
      .lo_out(dv_lo[k+1]), .q_out(dv_q[k+1])
    );
  end

  // Saturate, pick the half-root lane, zero on a bad radicand
  logic [LANES-1:0][DATA_W-1:0] comp;
  logic [D_W-1:0]               half;
  ctrl_t                        fc;
  assign fc   = dv_ctrl[Q_W];
  assign half = (D_W'(dv_d[Q_W][D_W-1:1]) + D_W'(1)) >> 1;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (fc.bad) begin
        comp[i] = '0;
      end else if (fc.sel == 2'(i)) begin
        comp[i] = (half > D_W'(SAT_MAX)) ? SAT_MAX : half[DATA_W-1:0];
      end else if (!fc.neg[i]) begin
        comp[i] = (fc.ovf[i] || dv_q[Q_W][i] > Q_W'(SAT_MAX)) ?
                  SAT_MAX : dv_q[Q_W][i][DATA_W-1:0];
      end else begin
        comp[i] = (fc.ovf[i] || dv_q[Q_W][i] > Q_W'(32768)) ?
                  SAT_MIN : DATA_W'(-dv_q[Q_W][i][DATA_W-1:0]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= fc.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= comp;
      m_tuser <= fc.bad;
    end
  end

  `RM2Q_ASSERT_IMP(a_bad_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == 64'd0)
  `RM2Q_ASSERT_IMP(a_one_nonneg, clk, rst, m_tvalid, !(m_tdata[15] && m_tdata[31] && m_tdata[47] && m_tdata[63]))
  `RM2Q_ASSERT_NEXT(a_rst_empty, clk, rst, !m_tvalid)
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the rotation matrix to quaternion converter.
`default_nettype none
module tb_top;
  import rm2q_pkg::*;

  localparam int ONE = 1 << 14;
  localparam int LATENCY = 40;
  localparam longint LIMIT = 1000000;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic               bad;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [143:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0] m_tuser;

  quat_t quat_q[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int bad_seen = 0;
  int branch_seen[4] = '{0, 0, 0, 0};
  longint cycles = 0;
  bit stall_enable = 1'b1;

  rotation_matrix_to_quaternion uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // Integer square root by bit pairs
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return SAT_MAX;
    if (v < -32768) return SAT_MIN;
    return v[15:0];
  endfunction

  // Numerator over twice the root, rounded to nearest, ties away from zero
  function automatic longint scaled_quot(longint n, longint unsigned t);
    longint unsigned mag, q;
    longint s;
    mag = (n < 0) ? -n : n;
    q = ((mag << 14) + t) / (2 * t);
    s = (q > 65536) ? 65536 : q;
    return (n < 0) ? -s : s;
  endfunction

  function automatic quat_t convert(logic [143:0] m);
    longint e[9];
    longint trace, rad;
    longint n[4];
    logic [1:0] sel;
    longint unsigned t;
    longint comp[4];
    quat_t q;
    for (int i = 0; i < 9; i++) e[i] = $signed(m[16*i +: 16]);
    trace = e[0] + e[4] + e[8];
    if (trace > 0) begin
      rad = ONE + trace; sel = SEL_W;
      n[0] = e[7] - e[5]; n[1] = e[2] - e[6]; n[2] = e[3] - e[1]; n[3] = 0;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      rad = ONE + e[0] - e[4] - e[8]; sel = SEL_X;
      n[0] = 0; n[1] = e[1] + e[3]; n[2] = e[2] + e[6]; n[3] = e[7] - e[5];
    end else if (e[4] > e[8]) begin
      rad = ONE + e[4] - e[0] - e[8]; sel = SEL_Y;
      n[0] = e[1] + e[3]; n[1] = 0; n[2] = e[5] + e[7]; n[3] = e[2] - e[6];
    end else begin
      rad = ONE + e[8] - e[0] - e[4]; sel = SEL_Z;
      n[0] = e[2] + e[6]; n[1] = e[5] + e[7]; n[2] = 0; n[3] = e[3] - e[1];
    end
    branch_seen[sel]++;
    if (rad <= 0) begin
      q = '0;
      q.bad = 1'b1;
      return q;
    end
    t = root_floor(longint'(rad) << 14);
    for (int i = 0; i < 4; i++)
      comp[i] = (i == sel) ? longint'((t + 1) >> 1) : scaled_quot(n[i], t);
    q.qx = clamp16(comp[0]);
    q.qy = clamp16(comp[1]);
    q.qz = clamp16(comp[2]);
    q.qw = clamp16(comp[3]);
    q.bad = 1'b0;
    return q;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Send one matrix, holding it until accepted
  task automatic send_matrix(logic [143:0] m, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= m;
    quat_q.push_back(convert(m));
    sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [143:0] pack9(int a11, int a12, int a13, int a21, int a22,
                                         int a23, int a31, int a32, int a33);
    return {a33[15:0], a32[15:0], a31[15:0], a23[15:0], a22[15:0], a21[15:0],
            a13[15:0], a12[15:0], a11[15:0]};
  endfunction

  // Random matrix element: mostly in -ONE..ONE, sometimes a full-scale or raw 16-bit value
  function automatic int rand_elem();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return $signed(16'($urandom));
      default: return $urandom_range(0, 2 * ONE) - ONE;
    endcase
  endfunction

  task automatic test_directed();
    send_matrix(pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 0);
    send_matrix(pack9(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 0);
    send_matrix(pack9(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE), 0);
    send_matrix(pack9(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE), 0);
    send_matrix(pack9(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE), 0);
    send_matrix(pack9(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_matrix(pack9(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 0);
    send_matrix(pack9(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0);
    send_matrix(pack9(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                      -32768), 0);
    send_matrix(pack9(0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0), 0);
    send_matrix(pack9(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 1), 0);
    send_matrix(pack9(-32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767), 0);
    send_matrix(pack9(1, 0, 0, 0, 1, 0, 0, 0, -2), 0);
    send_matrix(pack9(5, 0, 0, 0, 5, 0, 0, 0, 5), 0);
    send_matrix(pack9(32767, -32768, -32768, 32767, -32768, 0, 32767, 0, -32768), 0);
    send_matrix(pack9(-ONE, 1, 2, 3, -ONE, 4, 5, 6, -ONE - 1), 0);
    send_matrix({144{1'b1}}, 0);
    send_matrix({72{2'b10}}, 0);
    send_matrix({72{2'b01}}, 0);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_matrix({$urandom, $urandom, $urandom, $urandom, 16'($urandom)}, 1);
      else
        send_matrix(pack9(rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                          rand_elem(), rand_elem(), rand_elem(), rand_elem()), 1);
    end
  endtask

  // Full rate with the output always ready
  task automatic test_back_to_back(int count);
    stall_enable = 1'b0;
    for (int i = 0; i < count; i++)
      send_matrix(pack9(rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                        rand_elem(), rand_elem(), rand_elem(), rand_elem()), 0);
    stall_enable = 1'b1;
  endtask

  // Drive output readiness with random stalls
  initial begin
    int g;
    @(negedge rst);
    forever begin
      m_tready <= 1'b1;
      @(posedge clk);
      if (stall_enable && $urandom_range(0, 99) < 30) begin
        g = gap_len();
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  // Compare each output beat with the oldest prediction
  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst && m_tvalid && m_tready) begin
      received++;
      if (quat_q.size() == 0) begin
        $error("unexpected output beat %h", m_tdata);
        errors++;
      end else begin
        exp_q = quat_q.pop_front();
        if (m_tuser[0]) bad_seen++;
        if (m_tdata[15:0] !== exp_q.qx) begin
          $error("qx exp %0d got %0d", exp_q.qx, $signed(m_tdata[15:0])); errors++;
        end
        if (m_tdata[31:16] !== exp_q.qy) begin
          $error("qy exp %0d got %0d", exp_q.qy, $signed(m_tdata[31:16])); errors++;
        end
        if (m_tdata[47:32] !== exp_q.qz) begin
          $error("qz exp %0d got %0d", exp_q.qz, $signed(m_tdata[47:32])); errors++;
        end
        if (m_tdata[63:48] !== exp_q.qw) begin
          $error("qw exp %0d got %0d", exp_q.qw, $signed(m_tdata[63:48])); errors++;
        end
        if (m_tuser[0] !== exp_q.bad) begin
          $error("bad_input exp %0d got %0d", exp_q.bad, m_tuser[0]); errors++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("rotation_matrix_to_quaternion regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1500);
    test_back_to_back(200);
    s_tvalid <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (quat_q.size() != 0) errors++;
    $display("sent %0d matrices, checked %0d results, %0d flagged bad", sent, received,
             bad_seen);
    $display("branches hit: x %0d, y %0d, z %0d, trace %0d", branch_seen[SEL_X],
             branch_seen[SEL_Y], branch_seen[SEL_Z], branch_seen[SEL_W]);
    if (errors == 0) begin
      $display("rotation_matrix_to_quaternion regression: pass");
    end else begin
      $display("rotation_matrix_to_quaternion regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
